@@ sv/contiguous_pattern_search_top_defines.svh @@
// assertion helpers for the pattern search block
`ifndef CONTIGUOUS_PATTERN_SEARCH_TOP_DEFINES_SVH
`define CONTIGUOUS_PATTERN_SEARCH_TOP_DEFINES_SVH

// invariant checked at every clock edge outside reset
`define CPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define CPS_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> (conseq)) else $error(msg);

`endif

@@ sv/cps_pkg.sv @@
`default_nettype none

package cps_pkg;

  localparam int unsigned WordW = 32;

  typedef logic signed [WordW-1:0] word_t;

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } opcode_e;

endpackage

`default_nettype wire

@@ sv/cps_if.sv @@
`default_nettype none

// input channel: one pattern or text word per handshake
interface cps_in_if;
  logic              valid;
  logic              ready;
  cps_pkg::opcode_e  opcode;
  cps_pkg::word_t    value;
  logic              last;

  modport source (output valid, output opcode, output value, output last, input ready);
  modport sink   (input valid, input opcode, input value, input last, output ready);
endinterface

// result channel: one word per finished text
interface cps_out_if;
  logic valid;
  logic ready;
  logic found;
  logic pattern_overflow;

  modport source (output valid, output found, output pattern_overflow, input ready);
  modport sink   (input valid, input found, input pattern_overflow, output ready);
endinterface

`default_nettype wire

@@ sv/contiguous_pattern_search_top.sv @@
// contiguous pattern search over a stream of signed 32-bit words
// in_i carries pattern words (opcode OP_PATTERN) and text words (OP_TEXT);
// last closes a pattern or a text. a pattern keeps up to PAT_MAX words,
// extra words are dropped and flagged as overflow.
// out_o carries one word per text word marked last: found tells
// whether the stored pattern occurred as a contiguous run of that text,
// pattern_overflow whether the pattern was truncated. other words give none.
// the result word is valid in the cycle after the closing text word
// is accepted. throughput: one word per cycle, every word is handled in the
// cycle it is accepted (window shift plus a PAT_MAX-lane parallel compare
// against the pattern shift register feeding one result register).
// stall: in_i.ready drops only while a result word waits and out_o.ready is
// low; the result register then holds its word unchanged.
// reset: empty pattern, empty text window, no result pending; the first
// pattern word after reset starts a new pattern.
`default_nettype none

module contiguous_pattern_search_top #(
  parameter int unsigned PAT_MAX = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cps_in_if.sink     in_i,
  cps_out_if.source  out_o
);
  import cps_pkg::*;

`include "contiguous_pattern_search_top_defines.svh"

  localparam int unsigned CntW = $clog2(PAT_MAX + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(PAT_MAX);

  // pattern shift register: pat_q[0] is the newest (last) pattern word,
  // so it lines up with the newest text word in win_q[0]
  word_t           pat_q [PAT_MAX];
  word_t           win_q [PAT_MAX];
  logic [CntW-1:0] pat_len_q, pat_len_d;
  logic [CntW-1:0] seen_q, seen_d;
  logic            closed_q, closed_d;
  logic            ovf_q, ovf_d;
  logic            match_q, match_d;

  logic            out_valid_q, out_valid_d;
  logic            found_q, found_d;
  logic            out_ovf_q, out_ovf_d;

  logic            accept;
  logic            is_text;
  logic            text_end;
  logic            pat_shift;
  logic            window_hit;
  logic [PAT_MAX-1:0] lane_ok;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign is_text    = (in_i.opcode == OP_TEXT);
  assign text_end   = accept && is_text && in_i.last;

  // ---------------------------------------------------------------------------
  // pattern side
  // ---------------------------------------------------------------------------
  always_comb begin
    pat_len_d = pat_len_q;
    closed_d  = closed_q;
    ovf_d     = ovf_q;
    pat_shift = 1'b0;
    if (accept && !is_text) begin
      if (closed_q) begin
        // a new pattern starts with this word
        pat_len_d = CntW'(1);
        ovf_d     = 1'b0;
        pat_shift = 1'b1;
      end else if (pat_len_q != CntMax) begin
        pat_len_d = pat_len_q + 1'b1;
        pat_shift = 1'b1;
      end else begin
        // store full, word dropped
        ovf_d = 1'b1;
      end
      closed_d = in_i.last;
    end
  end

  // ---------------------------------------------------------------------------
  // parallel window compare, one lane per pattern position
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < PAT_MAX; k++) begin : g_lane
    localparam logic [CntW-1:0] LaneIdx = CntW'(k);
    word_t win_new;
    if (k == 0) begin : g_head
      assign win_new = in_i.value;
    end else begin : g_tail
      assign win_new = win_q[k-1];
    end
    // lanes past the pattern length do not take part
    assign lane_ok[k] = (LaneIdx >= pat_len_q) || (win_new == pat_q[k]);

    always_ff @(posedge clk_i) begin
      if (accept && is_text) begin
        win_q[k] <= win_new;
      end
      if (pat_shift) begin
        if (k == 0) begin
          pat_q[k] <= in_i.value;
        end else begin
          pat_q[k] <= pat_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  always_comb begin
    seen_d      = seen_q;
    match_d     = match_q;
    found_d     = found_q;
    out_ovf_d   = out_ovf_q;
    out_valid_d = out_valid_q;
    window_hit  = 1'b0;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (accept && is_text) begin
      seen_d = (seen_q == CntMax) ? seen_q : seen_q + 1'b1;
      // empty pattern never matches, nor one longer than the text so far
      window_hit = (pat_len_q != '0) && (seen_d >= pat_len_q) && (&lane_ok);
      match_d    = match_q || window_hit;
      if (in_i.last) begin
        found_d     = match_d;
        out_ovf_d   = ovf_q;
        out_valid_d = 1'b1;
        seen_d      = '0;
        match_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q   <= '0;
      closed_q    <= 1'b1;
      ovf_q       <= 1'b0;
      seen_q      <= '0;
      match_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pat_len_q   <= pat_len_d;
      closed_q    <= closed_d;
      ovf_q       <= ovf_d;
      seen_q      <= seen_d;
      match_q     <= match_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    found_q   <= found_d;
    out_ovf_q <= out_ovf_d;
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.found            = found_q;
  assign out_o.pattern_overflow = out_ovf_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `CPS_ASSERT_ALWAYS(a_len_bound, pat_len_q <= CntMax, "pattern length past PAT_MAX")
  `CPS_ASSERT_ALWAYS(a_seen_bound, seen_q <= CntMax, "text count past PAT_MAX")
  `CPS_ASSERT_ALWAYS(a_ovf_full, !ovf_q || (pat_len_q == CntMax), "overflow with room left")
  `CPS_ASSERT_NEXT(a_end_result, text_end, out_valid_q && seen_q == '0 && !match_q, "text end lost")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench;
  import cps_pkg::*;

  localparam int unsigned PAT_MAX = 16;
  // cycles without any handshake on either channel before the run is abandoned
  localparam int unsigned STALL_LIMIT = 2000;
  // random words per phase, three phases in all
  localparam int unsigned PHASE_WORDS = 650;

  typedef struct {
    opcode_e opcode;
    word_t   value;
    logic    last;
  } search_word_t;

  typedef struct {
    logic found;
    logic overflow;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cps_in_if  in_if();
  cps_out_if out_if();

  contiguous_pattern_search_top #(
    .PAT_MAX(PAT_MAX)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // words still to be offered and verdicts still to be seen on the result channel
  search_word_t words_to_send[$];
  verdict_t     pending_verdicts[$];
  search_word_t offered_word;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned phase_words   = 0;

  // shadow copy of the search state, updated on every accepted input word
  word_t       pat_words[PAT_MAX];
  int unsigned pat_len     = 0;
  bit          pat_closed  = 1'b1;
  bit          pat_ovf     = 1'b0;
  word_t       text_win[PAT_MAX];
  int unsigned text_cnt    = 0;
  bit          hit_latched = 1'b0;

  // fold one accepted word into the shadow state; a closing text word
  // yields the verdict the block must report for that text
  task automatic track_search_word(search_word_t w);
    bit hit;
    if (w.opcode == OP_PATTERN) begin
      // a word after a closed pattern starts a fresh one
      if (pat_closed) begin
        pat_len    = 0;
        pat_ovf    = 1'b0;
        pat_closed = 1'b0;
      end
      if (pat_len < PAT_MAX) begin
        pat_words[pat_len] = w.value;
        pat_len++;
      end else begin
        pat_ovf = 1'b1;
      end
      if (w.last) pat_closed = 1'b1;
    end else begin
      // text_win[0] is the newest text word
      for (int i = PAT_MAX - 1; i > 0; i--) text_win[i] = text_win[i-1];
      text_win[0] = w.value;
      if (text_cnt < PAT_MAX) text_cnt++;
      // empty pattern never hits, and no hit until enough text has come
      if (pat_len != 0 && text_cnt >= pat_len) begin
        hit = 1'b1;
        for (int k = 0; k < pat_len; k++) begin
          if (text_win[k] != pat_words[pat_len-1-k]) hit = 1'b0;
        end
        if (hit) hit_latched = 1'b1;
      end
      if (w.last) begin
        pending_verdicts.push_back('{found: hit_latched, overflow: pat_ovf});
        text_cnt    = 0;
        hit_latched = 1'b0;
      end
    end
  endtask

  task automatic add_word(opcode_e op, word_t value, logic last);
    words_to_send.push_back('{opcode: op, value: value, last: last});
    phase_words++;
  endtask

  // mostly a tiny alphabet so that chance hits happen, plus extremes and noise
  function automatic word_t pick_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return word_t'($urandom_range(3));
    if (r < 77) return 32'sh8000_0000;
    if (r < 84) return 32'sh7fff_ffff;
    if (r < 88) return -32'sd1;
    return word_t'($urandom);
  endfunction

  // one pattern followed by one text; the text often carries the pattern
  task automatic queue_search_job();
    word_t       pat[$];
    word_t       txt[$];
    int unsigned plen;
    int unsigned plen_kept;
    int unsigned tlen;
    int unsigned pos;
    int unsigned r;
    bit          close_pat;
    r = $urandom_range(99);
    if (r < 5) plen = 0;                            // keep the pattern stored now
    else if (r < 12) plen = $urandom_range(PAT_MAX + 1, PAT_MAX + 4); // truncated
    else if (r < 20) plen = $urandom_range(6, PAT_MAX);
    else plen = $urandom_range(1, 5);
    close_pat = ($urandom_range(99) >= 5);
    for (int i = 0; i < plen; i++) begin
      pat.push_back(pick_word());
      add_word(OP_PATTERN, pat[i], close_pat && (i == plen - 1));
    end
    plen_kept = (plen > PAT_MAX) ? PAT_MAX : plen;

    tlen = ($urandom_range(99) < 20) ? $urandom_range(10, 24) : $urandom_range(1, 8);
    for (int i = 0; i < tlen; i++) txt.push_back(pick_word());
    if (plen_kept != 0 && plen_kept <= tlen && $urandom_range(99) < 55) begin
      pos = $urandom_range(tlen - plen_kept);
      for (int i = 0; i < plen_kept; i++) txt[pos+i] = pat[i];
    end

    // now and then a pattern word lands in the middle of the text
    pos = ($urandom_range(99) < 10) ? $urandom_range(tlen - 1) : tlen;
    for (int i = 0; i < tlen; i++) begin
      if (i == pos) add_word(OP_PATTERN, pick_word(), logic'($urandom_range(1)));
      add_word(OP_TEXT, txt[i], i == tlen - 1);
    end
  endtask

  // hold off until every offered word is taken and every verdict has come
  task automatic wait_for_drain();
    while (words_to_send.size() != 0 || in_if.valid || pending_verdicts.size() != 0)
      @(negedge clk_i);
  endtask

  // input driver: a new word may be offered once the current one is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) track_search_word(offered_word);
      if (!in_if.valid || in_if.ready) begin
        if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_word = words_to_send.pop_front();
          in_if.valid  <= 1'b1;
          in_if.opcode <= offered_word.opcode;
          in_if.value  <= offered_word.value;
          in_if.last   <= offered_word.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each taken verdict with the oldest one predicted,
  // and stall the result channel at random
  always @(posedge clk_i) begin
    verdict_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected result, found %b pattern_overflow %b", $time,
                   out_if.found, out_if.pattern_overflow);
          mismatches++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_if.found !== want.found) begin
            $display("%0t: found expected %b actual %b", $time, want.found, out_if.found);
            mismatches++;
          end
          if (out_if.pattern_overflow !== want.overflow) begin
            $display("%0t: pattern_overflow expected %b actual %b", $time,
                     want.overflow, out_if.pattern_overflow);
            mismatches++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // give up when neither channel moves for too long
  initial begin : watchdog
    int unsigned stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    // every block input known from time zero
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.opcode     = OP_PATTERN;
    in_if.value      = '0;
    in_if.last       = 1'b0;
    out_if.ready     = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed words
    // text with no pattern stored yet: an empty pattern is never found
    add_word(OP_TEXT, 32'sh7fff_ffff, 1'b1);
    // pattern of both extremes, then a text ending in it
    add_word(OP_PATTERN, 32'sh8000_0000, 1'b0);
    add_word(OP_PATTERN, 32'sh7fff_ffff, 1'b1);
    add_word(OP_TEXT, 32'sd0, 1'b0);
    add_word(OP_TEXT, 32'sh8000_0000, 1'b0);
    add_word(OP_TEXT, 32'sh7fff_ffff, 1'b1);
    // text shorter than the pattern cannot match
    add_word(OP_TEXT, 32'sh7fff_ffff, 1'b1);
    // one word more than the store holds: truncated and flagged
    for (int i = 0; i <= PAT_MAX; i++) add_word(OP_PATTERN, word_t'(i), i == PAT_MAX);
    add_word(OP_TEXT, word_t'(PAT_MAX), 1'b1);

    // phase one: sender idles often, receiver idles most of the time
    send_idle_pct = 38;
    recv_idle_pct = 87;
    phase_words   = 0;
    while (phase_words < PHASE_WORDS) queue_search_job();
    wait_for_drain();

    // phase two: roles swapped; the drain above is the sender's full pause
    send_idle_pct = 87;
    recv_idle_pct = 38;
    phase_words   = 0;
    while (phase_words < PHASE_WORDS) queue_search_job();
    wait_for_drain();

    // phase three: both sides at full rate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase_words   = 0;
    while (phase_words < PHASE_WORDS) queue_search_job();
    wait_for_drain();

    // let the clock run on so that any stray result would still be caught
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+sv
sv/cps_pkg.sv
sv/cps_if.sv
sv/contiguous_pattern_search_top.sv
tb/testbench.sv
